/* hdl/hasp_pkg.sv */
`default_nettype none
package hasp_pkg;
    localparam int Slots      = 16;
    localparam int SlotW      = $clog2(Slots);
    localparam int BucketBits = 4;
    localparam int QDepth     = 2;

    typedef enum logic [2:0] {
        CFG_BASE_A = 3'd0,
        CFG_BASE_B = 3'd1,
        CFG_BASE_C = 3'd2,
        CFG_DECAY  = 3'd3,
        CFG_INC    = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef struct packed {
        logic        operation;
        logic [31:0] sample_address;
        logic [3:0]  read_slot;
    } t_in;

    typedef struct packed {
        logic        was_ignored;
        logic [3:0]  slot_index;
        logic [31:0] bucket_address;
        logic [31:0] slot_hits;
        logic [10:0] slot_ratio;
        logic [31:0] total_hits;
    } t_out;

    // classified request passed from front to back
    typedef struct packed {
        logic        rd;
        logic        ign;
        logic [31:0] bucket;
        logic [3:0]  slot;
    } t_cmd;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
        return (a > b) ? a - b : 32'd0;
    endfunction
endpackage
`default_nettype wire

/* hdl/hasp_front.sv */
`default_nettype none
module hasp_front import hasp_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire t_in    i_data,
    input  wire [31:0]  i_base_a,
    input  wire [31:0]  i_base_b,
    input  wire [31:0]  i_base_c,
    output logic        o_cmd_valid,
    input  wire         i_cmd_ready,
    output t_cmd        o_cmd
);
    localparam int QW = $clog2(QDepth);
    t_cmd            r_q [QDepth];
    logic [QW-1:0]   r_wp, r_rp;
    logic [QW:0]     r_cnt;
    logic            push, pop;
    t_cmd            cls;

    function automatic logic hit(input logic [31:0] pc, input logic [31:0] b);
        logic [31:0] d;
        d = pc - b;
        return (pc >= b) && ((d >> BucketBits) == 32'd0);
    endfunction

    always_comb begin
        cls.rd     = (i_data.operation == OP_READ);
        cls.ign    = hit(i_data.sample_address, i_base_a) |
                     hit(i_data.sample_address, i_base_b) |
                     hit(i_data.sample_address, i_base_c);
        cls.bucket = (i_data.sample_address >> BucketBits) << BucketBits;
        cls.slot   = i_data.read_slot;
    end

    assign o_ready     = (r_cnt != (QW+1)'(QDepth));
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= cls;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QW+1)'(push) - (QW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

/* hdl/hasp_div.sv */
`default_nettype none
module hasp_div import hasp_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire [31:0]  i_num,
    input  wire [31:0]  i_den,
    output logic        o_done,
    output logic [10:0] o_ratio
);
    // restoring divide of num*1024 by den, one quotient bit per cycle
    logic [42:0] r_rem_num;
    logic [32:0] r_rem;
    logic [42:0] r_quo;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [31:0] r_den;
    logic [33:0] trial;

    assign trial = {r_rem, r_rem_num[42]} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; o_done <= 1'b0; r_cnt <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1; r_cnt <= 6'd43;
                r_rem_num <= {1'b0, i_num, 10'd0};
                r_rem <= '0; r_quo <= '0; r_den <= i_den;
            end else if (r_busy) begin
                r_rem_num <= r_rem_num << 1;
                if (!trial[33]) begin
                    r_rem <= trial[32:0]; r_quo <= {r_quo[41:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[31:0], r_rem_num[42]}; r_quo <= {r_quo[41:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0; o_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_den == '0)             o_ratio = '0;
        else if (r_quo > 43'd1024)   o_ratio = 11'd1024;
        else                         o_ratio = r_quo[10:0];
    end
endmodule
`default_nettype wire

/* hdl/hasp_back.sv */
`default_nettype none
module hasp_back import hasp_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cmd_valid,
    output logic        o_cmd_ready,
    input  wire t_cmd   i_cmd,
    input  wire         i_decay_en,
    input  wire [7:0]   i_inc,
    output logic        o_valid,
    input  wire         i_ready,
    output t_out        o_data
);
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SEARCH = 7'b0000010,
        S_APPLY  = 7'b0000100,
        S_DIV    = 7'b0001000,
        S_WAIT   = 7'b0010000,
        S_BUBBLE = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state          r_st;
    logic [31:0]     r_bkt [Slots];
    logic [31:0]     r_cnt [Slots];
    logic [10:0]     r_rat [Slots];
    logic [31:0]     r_tot;
    logic [SlotW-1:0] r_dp, r_i, r_idx;
    logic [SlotW:0]  r_found, r_free;
    t_cmd            r_cmd;
    logic            div_start, div_done;
    logic [10:0]     div_ratio;
    logic [31:0]     new_cnt, new_tot;
    t_out            n_out;

    hasp_div u_div (
        .i_clk, .i_rst_n, .i_start(div_start),
        .i_num(r_cnt[r_idx]), .i_den(r_tot),
        .o_done(div_done), .o_ratio(div_ratio)
    );

    assign o_cmd_ready = (r_st == S_IDLE) && !o_valid;
    assign div_start   = (r_st == S_DIV);

    always_comb begin
        new_tot = r_tot;
        new_cnt = r_cnt[r_idx];
        if (r_found == (SlotW+1)'(Slots) && r_free == (SlotW+1)'(Slots)) begin
            new_tot = sat_sub(r_tot, r_cnt[r_idx]);
            new_cnt = '0;
        end
        new_tot = sat_add(new_tot, {24'd0, i_inc});
        new_cnt = sat_add(new_cnt, {24'd0, i_inc});
    end

    always_comb begin
        n_out = '0;
        n_out.total_hits = r_tot;
        if (r_st == S_OUT) begin
            n_out.slot_index     = 4'(r_idx);
            n_out.bucket_address = r_bkt[r_idx];
            n_out.slot_hits      = r_cnt[r_idx];
            n_out.slot_ratio     = r_rat[r_idx];
        end else if (i_cmd.rd) begin
            n_out.slot_index = i_cmd.slot;
            if ({1'b0, i_cmd.slot} < (SlotW+1)'(Slots)) begin
                n_out.bucket_address = r_bkt[i_cmd.slot[SlotW-1:0]];
                n_out.slot_hits      = r_cnt[i_cmd.slot[SlotW-1:0]];
                n_out.slot_ratio     = r_rat[i_cmd.slot[SlotW-1:0]];
            end
        end else begin
            n_out.was_ignored = i_cmd.ign;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; o_valid <= 1'b0; r_tot <= '0; r_dp <= '0;
            for (int k = 0; k < Slots; k++) begin
                r_bkt[k] <= '0; r_cnt[k] <= '0; r_rat[k] <= '0;
            end
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            case (r_st)
                S_IDLE: if (i_cmd_valid && o_cmd_ready) begin
                    r_cmd <= i_cmd;
                    o_data <= n_out;
                    if (i_cmd.rd) begin
                        o_valid <= 1'b1;
                    end else if (i_cmd.ign) begin
                        o_valid <= 1'b1;
                    end else begin
                        if (i_decay_en) begin
                            if (r_cnt[r_dp] > 32'd1) begin
                                r_cnt[r_dp] <= r_cnt[r_dp] - 1'b1;
                                r_tot <= sat_sub(r_tot, 32'd1);
                            end
                            r_dp <= (r_dp == SlotW'(Slots-1)) ? '0 : r_dp + 1'b1;
                        end
                        r_i <= '0;
                        r_found <= (SlotW+1)'(Slots);
                        r_free  <= (SlotW+1)'(Slots);
                        r_st <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (r_bkt[r_i] == r_cmd.bucket) begin
                        r_found <= {1'b0, r_i}; r_idx <= r_i; r_st <= S_APPLY;
                    end else begin
                        if (r_free == (SlotW+1)'(Slots) && r_cnt[r_i] == '0)
                            r_free <= {1'b0, r_i};
                        if (r_i == SlotW'(Slots-1)) begin
                            r_idx <= (r_free != (SlotW+1)'(Slots)) ? r_free[SlotW-1:0] :
                                     (r_cnt[r_i] == '0) ? r_i : SlotW'(Slots-1);
                            r_st <= S_APPLY;
                        end
                        r_i <= r_i + 1'b1;
                    end
                end
                S_APPLY: begin
                    r_bkt[r_idx] <= r_cmd.bucket;
                    r_cnt[r_idx] <= new_cnt;
                    r_tot <= new_tot;
                    r_st <= S_DIV;
                end
                S_DIV: r_st <= S_WAIT;
                S_WAIT: if (div_done) begin
                    r_rat[r_idx] <= div_ratio;
                    r_st <= S_BUBBLE;
                end
                S_BUBBLE: begin
                    if (r_idx != '0 && r_cnt[r_idx] > r_cnt[r_idx - 1'b1]) begin
                        r_bkt[r_idx] <= r_bkt[r_idx - 1'b1];
                        r_cnt[r_idx] <= r_cnt[r_idx - 1'b1];
                        r_rat[r_idx] <= r_rat[r_idx - 1'b1];
                        r_bkt[r_idx - 1'b1] <= r_bkt[r_idx];
                        r_cnt[r_idx - 1'b1] <= r_cnt[r_idx];
                        r_rat[r_idx - 1'b1] <= r_rat[r_idx];
                        r_idx <= r_idx - 1'b1;
                    end else begin
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    o_data  <= n_out;
                    o_valid <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* hdl/hot_address_sampling_profiler.sv */
`default_nettype none
// Hot-address profiler: keeps sixteen 16-byte buckets ordered by hit count.
// Reads and ignored samples are answered from the output register once the engine
// takes them from the queue; a kept sample goes through a table search, the serial
// ratio divide and bubble steps toward slot zero before its result. A two-entry
// queue sits between the input classifier and the table engine.
module hot_address_sampling_profiler import hasp_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire t_in    i_data,
    output logic        o_valid,
    input  wire         i_ready,
    output t_out        o_data,
    input  wire         i_cfg_we,
    input  wire [2:0]   i_cfg_idx,
    input  wire [31:0]  i_cfg_data
);
    logic [31:0] r_base_a, r_base_b, r_base_c;
    logic        r_decay;
    logic [7:0]  r_inc;
    logic        cmd_valid, cmd_ready;
    t_cmd        cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_a <= 32'hbf802a0a; r_base_b <= '0; r_base_c <= '0;
            r_decay <= 1'b1; r_inc <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE_A: r_base_a <= i_cfg_data;
                CFG_BASE_B: r_base_b <= i_cfg_data;
                CFG_BASE_C: r_base_c <= i_cfg_data;
                CFG_DECAY:  r_decay  <= i_cfg_data[0];
                CFG_INC:    r_inc    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    hasp_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data,
        .i_base_a(r_base_a), .i_base_b(r_base_b), .i_base_c(r_base_c),
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    hasp_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready),
        .i_cmd(cmd), .i_decay_en(r_decay), .i_inc(r_inc),
        .o_valid, .i_ready, .o_data
    );

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result dropped while stalled");
    a_ign_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.was_ignored |-> o_data.slot_hits == '0)
        else $error("ignored sample carries hits");
    a_ratio_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.slot_ratio <= 11'd1024)
        else $error("ratio above clamp");
endmodule
`default_nettype wire

/* verif/tb_hot_address_sampling_profiler.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_hot_address_sampling_profiler;
    import hasp_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in         i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out        o_data;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    hot_address_sampling_profiler DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // profiler table mirror
    logic [31:0] tbl_bucket [Slots];
    logic [31:0] tbl_count  [Slots];
    logic [10:0] tbl_ratio  [Slots];
    logic [31:0] hits_total;
    logic [3:0]  decay_ptr;
    logic [31:0] base_a, base_b, base_c;
    logic        decay_on;
    logic [7:0]  hit_inc;

    t_out expected_q[$];
    int   n_mismatch = 0;
    bit   no_idle = 1'b0;
    bit   hold_off = 1'b0;

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic bit ignored_by(logic [31:0] pc, logic [31:0] base);
        return pc >= base && (pc - base) < (32'd1 << BucketBits);
    endfunction

    function automatic int credit_hit(int slot, logic [31:0] bkt);
        logic [63:0] r;
        logic [31:0] tb, tc;
        logic [10:0] tr;
        tbl_bucket[slot] = bkt;
        hits_total = add_sat(hits_total, {24'd0, hit_inc});
        tbl_count[slot] = add_sat(tbl_count[slot], {24'd0, hit_inc});
        if (hits_total == 0) r = 0;
        else begin
            r = ({32'd0, tbl_count[slot]} << 10) / {32'd0, hits_total};
            if (r > 1024) r = 1024;
        end
        tbl_ratio[slot] = r[10:0];
        while (slot > 0 && tbl_count[slot] > tbl_count[slot-1]) begin
            tb = tbl_bucket[slot]; tc = tbl_count[slot]; tr = tbl_ratio[slot];
            tbl_bucket[slot] = tbl_bucket[slot-1];
            tbl_count[slot] = tbl_count[slot-1];
            tbl_ratio[slot] = tbl_ratio[slot-1];
            tbl_bucket[slot-1] = tb; tbl_count[slot-1] = tc; tbl_ratio[slot-1] = tr;
            slot--;
        end
        return slot;
    endfunction

    function automatic t_out profile_request(t_in req);
        t_out o;
        logic [31:0] bkt;
        int found, free_slot, slot;
        o = '0;
        found = Slots; free_slot = Slots;
        bkt = req.sample_address & (32'hFFFF_FFFF << BucketBits);
        if (t_op'(req.operation) == OP_READ) begin
            o.slot_index = req.read_slot;
            o.bucket_address = tbl_bucket[req.read_slot];
            o.slot_hits = tbl_count[req.read_slot];
            o.slot_ratio = tbl_ratio[req.read_slot];
            o.total_hits = hits_total;
            return o;
        end
        if (ignored_by(req.sample_address, base_a) || ignored_by(req.sample_address, base_b)
                || ignored_by(req.sample_address, base_c)) begin
            o.was_ignored = 1'b1;
            o.total_hits = hits_total;
            return o;
        end
        if (decay_on) begin
            if (tbl_count[decay_ptr] > 1) begin
                tbl_count[decay_ptr]--;
                if (hits_total > 0) hits_total--;
            end
            decay_ptr++;
        end
        for (int i = 0; i < Slots; i++) begin
            if (tbl_bucket[i] == bkt) begin
                found = i;
                break;
            end
            if (free_slot == Slots && tbl_count[i] == 0) free_slot = i;
        end
        if (found < Slots) slot = credit_hit(found, bkt);
        else if (free_slot < Slots) slot = credit_hit(free_slot, bkt);
        else begin
            hits_total = (hits_total > tbl_count[Slots-1]) ?
                         hits_total - tbl_count[Slots-1] : 32'd0;
            tbl_count[Slots-1] = 0;
            slot = credit_hit(Slots - 1, bkt);
        end
        o.slot_index = slot[3:0];
        o.bucket_address = tbl_bucket[slot];
        o.slot_hits = tbl_count[slot];
        o.slot_ratio = tbl_ratio[slot];
        o.total_hits = hits_total;
        return o;
    endfunction

    task automatic send_request(t_in req);
        while (!no_idle && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= req;
        expected_q.push_back(profile_request(req));
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic record(logic [31:0] pc);
        t_in r;
        r = '0; r.operation = OP_RECORD; r.sample_address = pc; r.read_slot = 4'($urandom);
        send_request(r);
    endtask

    task automatic read_slot(logic [3:0] s);
        t_in r;
        r = '0; r.operation = OP_READ; r.read_slot = s; r.sample_address = $urandom;
        send_request(r);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_BASE_A: base_a = val;
            CFG_BASE_B: base_b = val;
            CFG_BASE_C: base_c = val;
            CFG_DECAY:  decay_on = val[0];
            CFG_INC:    hit_inc = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_all(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                           logic d, logic [7:0] inc);
        write_reg(CFG_BASE_A, a); write_reg(CFG_BASE_B, b); write_reg(CFG_BASE_C, c);
        write_reg(CFG_DECAY, {31'd0, d}); write_reg(CFG_INC, {24'd0, inc});
        i_cfg_we <= 1'b0;
    endtask

    // random sample biased toward a small working set so buckets recur
    task automatic random_traffic(int n);
        logic [31:0] pc;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0) read_slot(4'($urandom));
            else begin
                case ($urandom_range(3))
                    0: pc = $urandom;
                    1: pc = 32'h8000_0000 + ($urandom_range(23) << 4) + $urandom_range(15);
                    2: pc = base_a + $urandom_range(17) - 1;
                    default: pc = 32'h1000 + ($urandom_range(5) << 4) + $urandom_range(15);
                endcase
                record(pc);
            end
        end
    endtask

    task automatic test_directed();
        record(32'h0000_0000);
        record(32'hFFFF_FFFF);
        record(32'hBF80_2A0A);
        record(32'hBF80_2A19);
        record(32'hBF80_2A1A);
        record(32'hBF80_2A09);
        record(32'h0000_000F);
        record(32'h0000_0010);
        record(32'hAAAA_5555);
        record(32'h5555_AAAA);
        read_slot(4'd0);
        read_slot(4'd15);
        read_slot(4'd1);
        drain();
    endtask

    task automatic test_eviction_and_saturation();
        set_all(32'hFFFF_FFF0, 32'h0, 32'h0000_0020, 1'b0, 8'd255);
        for (int k = 0; k < 20; k++) record(32'h4000_0000 + (k << 4));
        record(32'hFFFF_FFF3);
        record(32'h0000_0005);
        record(32'h0000_0025);
        for (int k = 0; k < 16; k++) read_slot(k[3:0]);
        drain();
    endtask

    task automatic test_random();
        set_all(32'hBF80_2A0A, 32'h0, 32'h0, 1'b1, 8'd1);
        random_traffic(450);
        drain();
        set_all($urandom, 32'h8000_0040, $urandom, 1'b0, 8'd255);
        no_idle = 1'b1;
        random_traffic(250);
        no_idle = 1'b0;
        drain();
        set_all(32'h0000_1010, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 8'($urandom_range(1, 254)));
        random_traffic(450);
        drain();
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            random_traffic(200);
            begin
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join
        drain();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && hold_off) i_ready <= 1'b0;
        else i_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 8);
    end

    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result %p", o_data);
            end else begin
                exp_r = expected_q.pop_front();
                if (o_data !== exp_r) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) $display("mismatch: expected %p got %p", exp_r, o_data);
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < Slots; i++) begin
            tbl_bucket[i] = 0; tbl_count[i] = 0; tbl_ratio[i] = 0;
        end
        hits_total = 0; decay_ptr = 0;
        base_a = 32'hBF80_2A0A; base_b = 0; base_c = 0; decay_on = 1'b1; hit_inc = 8'd1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);
        test_directed();
        test_eviction_and_saturation();
        test_random();
        test_backpressure();
        if (n_mismatch == 0 && expected_q.size() == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    initial begin
        #30ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
